@@ hdl/deq_pkg.sv @@
// shared types and codes of the double-ended queue
`timescale 1ns / 1ps

package deq_pkg;

  // ring depth; the address and count widths follow from it
  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // operation codes
  localparam logic [2:0] KIND_PUSH_REAR  = 3'd0;
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [2:0] KIND_POP_REAR   = 3'd2;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
  localparam logic [2:0] KIND_CLEAR      = 3'd4;
  localparam logic [2:0] KIND_QUERY      = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [DATA_W-1:0] EMPTY_READ = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] push_value;
  } deq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic [CNT_W-1:0]         item_count;
    logic                     is_empty;
    logic [1:0]               status;
  } deq_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic exec;
    logic read;
  } deq_cmd_t;

endpackage

@@ hdl/deq_ram.sv @@
// generic ram, one write port, two registered read ports
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

@@ hdl/deq_ctrl.sv @@
// sequencing controller of the double-ended queue
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output deq_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC:  state_nxt = S_READ;
      S_READ:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign cmd.latch = (state_r == S_IDLE) && start;
  assign cmd.exec  = (state_r == S_EXEC);
  assign cmd.read  = (state_r == S_READ);

endmodule

@@ hdl/deq_dp.sv @@
// datapath: head, count, status registers and the slot ram
`timescale 1ns / 1ps

module deq_dp import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  deq_cmd_t cmd,
  input  deq_in_t  in_item,
  output deq_out_t out_result
);

  deq_in_t           item_r;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]        status_r, status_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr1;
  logic [DATA_W-1:0] rdata0, rdata1;
  logic              full, empty;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    we         = 1'b0;
    waddr      = head_r + count_r[ADDR_W-1:0];
    case (item_r.kind)
      KIND_PUSH_REAR: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          we        = 1'b1;
          waddr     = head_r - 1'b1;
          head_nxt  = head_r - 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      KIND_POP_REAR: begin
        if (empty) status_nxt = ST_EMPTY;
        else       count_nxt  = count_r - 1'b1;
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_nxt  = head_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      KIND_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
        // query and unused kinds leave the state alone
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      status_r <= ST_OK;
    end else if (cmd.exec) begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  // rear slot of the updated ring
  assign raddr1 = head_r + count_r[ADDR_W-1:0] - 1'b1;

  deq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we && cmd.exec),
    .waddr (waddr),
    .wdata (item_r.push_value),
    .re    (cmd.read),
    .raddr0(head_r),
    .raddr1(raddr1),
    .rdata0(rdata0),
    .rdata1(rdata1)
  );

  assign out_result.front_value = empty ? EMPTY_READ : $signed(rdata0);
  assign out_result.rear_value  = empty ? EMPTY_READ : $signed(rdata1);
  assign out_result.item_count  = count_r;
  assign out_result.is_empty    = empty;
  assign out_result.status      = status_r;

endmodule

@@ hdl/double_ended_queue.sv @@
// top level of the bounded double-ended queue
`timescale 1ns / 1ps

// bounded double-ended queue of signed 32-bit values, 16 slots in a ring
// input channel: present in_item and raise start; the transaction is taken
//   at the rising edge where start is high and busy is low
// in_item.kind: push rear, push front, pop rear, pop front, clear, query;
//   unused codes act as query
// result channel: out_valid is high for exactly one cycle with out_result,
//   which gives front and rear values, count, empty flag and status
// result: out_valid rises after the controller steps through accept,
//   update, ram read and deliver; busy stays high until the result is
//   delivered, so a new transaction is taken only after the last result;
//   the slot ram read port returns registered data the cycle after the address
// front and rear read as the most negative value while the queue is empty
// push to a full queue and pop from an empty one change nothing and are
//   flagged in status
// reset (synchronous, rst_n low) empties the queue and returns to idle;
//   slot contents are not cleared and need not be
// the receiver cannot stall: each result must be taken in its strobe cycle
module double_ended_queue import deq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  deq_in_t  in_item,
  output logic     out_valid,
  output deq_out_t out_result
);

  deq_cmd_t cmd;

  // sequencer
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  // pointers, count and slot storage
  deq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .out_result(out_result)
  );

endmodule
